// ----- rtl/core/a4icd_pkg.sv -----
`timescale 1ns / 1ps

package a4icd_pkg;

  localparam int unsigned InstrWidth = 32;
  localparam int unsigned ClassWidth = 4;

  typedef logic [InstrWidth-1:0] instr_t;
  typedef logic [ClassWidth-1:0] class_t;

  localparam class_t CLS_DATAPROC   = 4'd0;
  localparam class_t CLS_PSR        = 4'd1;
  localparam class_t CLS_MUL        = 4'd2;
  localparam class_t CLS_SWAP       = 4'd3;
  localparam class_t CLS_LDST_EXTRA = 4'd4;
  localparam class_t CLS_LDST       = 4'd5;
  localparam class_t CLS_LDM_STM    = 4'd6;
  localparam class_t CLS_BRANCH     = 4'd7;
  localparam class_t CLS_LDC_STC    = 4'd8;
  localparam class_t CLS_SWI        = 4'd9;
  localparam class_t CLS_MRC_MCR    = 4'd10;
  localparam class_t CLS_CDP        = 4'd11;
  localparam class_t CLS_UNDEF      = 4'd12;

  // Major opcode groups, bits 27:25
  localparam logic [2:0] GRP_DP_REG  = 3'b000;
  localparam logic [2:0] GRP_DP_IMM  = 3'b001;
  localparam logic [2:0] GRP_LDST_IM = 3'b010;
  localparam logic [2:0] GRP_LDST_RG = 3'b011;
  localparam logic [2:0] GRP_LDM     = 3'b100;
  localparam logic [2:0] GRP_BRANCH  = 3'b101;
  localparam logic [2:0] GRP_CP_LDST = 3'b110;
  localparam logic [2:0] GRP_CP_SWI  = 3'b111;

  // Shift-type field, bits 6:5, in the multiply / extra load-store space
  localparam logic [1:0] SH_MUL_SWP  = 2'b00;
  localparam logic [1:0] SH_HALFWORD = 2'b01;

  function automatic logic misc_pattern(input instr_t w);
    misc_pattern = w[24] & ~w[23] & ~w[20];
  endfunction

  function automatic class_t decode_mul_extra(input instr_t w);
    class_t c;
    c = CLS_UNDEF;
    case (w[6:5])
      SH_MUL_SWP: begin
        if (w[24:22] == 3'b000) begin
          c = CLS_MUL;
        end else if (w[24:23] == 2'b01) begin
          c = CLS_MUL;
        end else if (w[24:23] == 2'b10 && w[21:20] == 2'b00) begin
          c = CLS_SWAP;
        end else begin
          c = CLS_UNDEF;
        end
      end
      SH_HALFWORD: c = CLS_LDST_EXTRA;
      default:     c = w[20] ? CLS_LDST_EXTRA : CLS_UNDEF;
    endcase
    return c;
  endfunction

  function automatic class_t decode_group0(input instr_t w);
    class_t c;
    c = CLS_DATAPROC;
    if (!w[4]) begin
      if (misc_pattern(w)) begin
        c = (w[7:4] == 4'h0) ? CLS_PSR : CLS_UNDEF;
      end
    end else if (!w[7]) begin
      if (misc_pattern(w)) begin
        c = (w[7:4] == 4'h1 && w[22:21] == 2'b01) ? CLS_BRANCH : CLS_UNDEF;
      end
    end else begin
      c = decode_mul_extra(w);
    end
    return c;
  endfunction

  function automatic class_t classify(input instr_t w);
    class_t c;
    c = CLS_UNDEF;
    case (w[27:25])
      GRP_DP_REG: c = decode_group0(w);
      GRP_DP_IMM: begin
        if (misc_pattern(w)) begin
          c = w[21] ? CLS_PSR : CLS_UNDEF;
        end else begin
          c = CLS_DATAPROC;
        end
      end
      GRP_LDST_IM: c = CLS_LDST;
      GRP_LDST_RG: c = w[4] ? CLS_UNDEF : CLS_LDST;
      GRP_LDM:     c = CLS_LDM_STM;
      GRP_BRANCH:  c = CLS_BRANCH;
      GRP_CP_LDST: c = CLS_LDC_STC;
      GRP_CP_SWI: begin
        if (w[24]) begin
          c = CLS_SWI;
        end else begin
          c = w[4] ? CLS_MRC_MCR : CLS_CDP;
        end
      end
      default: c = CLS_UNDEF;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/armv4_instruction_class_decoder_unit.sv -----
`timescale 1ns / 1ps

// ARMv4 instruction class decoder.
// Input channel: in_valid / in_ready carry one 32-bit instruction word per
// item on in_instruction_word. The condition field is not looked at.
// Result channel: out_valid / out_ready carry the 4-bit class code on
// out_instruction_class (0 data processing .. 11 coprocessor data
// processing, 12 undefined).
// Path: an accepted item is held in the input register, passes the decode
// tree, and its class is loaded into the result register; two register
// stages in all (input register, then result register).
// Throughput: one item per cycle while out_ready is high, set by the single
// decode stage; each register stage refills in the cycle it drains.
// Stall: when out_ready is low the result register holds its item, the
// input register fills behind it, and in_ready falls only when both are
// full. Nothing is dropped or repeated.
// Reset: rst_n low at a clock edge empties both stages; in_ready is high
// and out_valid low from the first cycle after reset.
module armv4_instruction_class_decoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  a4icd_pkg::instr_t   in_instruction_word,
  output logic                out_valid,
  input  logic                out_ready,
  output a4icd_pkg::class_t   out_instruction_class
);

  import a4icd_pkg::*;

  logic   s1_valid_r, s1_valid_nxt;
  instr_t instr_r;
  logic   out_valid_r, out_valid_nxt;
  class_t class_r;
  logic   s2_ready;
  logic   in_fire;
  logic   s1_move;

  assign s2_ready = ~out_valid_r | out_ready;
  assign in_ready = ~s1_valid_r | s2_ready;
  assign in_fire  = in_valid & in_ready;
  assign s1_move  = s1_valid_r & s2_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s2_ready) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: load only when the stage takes a new item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      instr_r <= in_instruction_word;
    end
    if (s1_move) begin
      class_r <= classify(instr_r);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_instruction_class = class_r;

  a_class_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (class_r <= CLS_UNDEF))
    else $error("class code out of range");

  a_decode_matches: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> (out_valid_r && class_r == classify($past(instr_r))))
    else $error("result register does not hold the decoded item");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with room in the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("pipeline not empty after reset");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> (s1_valid_r && $stable(instr_r)))
    else $error("held item in input register lost");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import a4icd_pkg::*;

  localparam int unsigned StallLimit = 2000;

  typedef struct {
    instr_t word;
    class_t cls;
  } pending_class_t;

  class class_ledger;
    pending_class_t expected_classes[$];
    int unsigned    errors;

    function new();
      errors = 0;
    endfunction

    function class_t predicted_class(input instr_t w);
      logic       misc;
      logic [3:0] nib;
      class_t     c;
      misc = w[24] && !w[23] && !w[20];
      nib  = w[7:4];
      c    = CLS_UNDEF;
      case (w[27:25])
        GRP_DP_REG: begin
          if (!w[4]) begin
            c = !misc ? CLS_DATAPROC : (nib == 4'h0 ? CLS_PSR : CLS_UNDEF);
          end else if (!w[7]) begin
            c = !misc ? CLS_DATAPROC :
                ((nib == 4'h1 && w[22:21] == 2'b01) ? CLS_BRANCH : CLS_UNDEF);
          end else if (w[6:5] == SH_MUL_SWP) begin
            if (w[24:22] == 3'b000 || w[24:23] == 2'b01) begin
              c = CLS_MUL;
            end else if ((w[24:20] & 5'b11011) == 5'b10000) begin
              c = CLS_SWAP;
            end else begin
              c = CLS_UNDEF;
            end
          end else if (w[6:5] == SH_HALFWORD || w[20]) begin
            c = CLS_LDST_EXTRA;
          end else begin
            c = CLS_UNDEF;
          end
        end
        GRP_DP_IMM:  c = !misc ? CLS_DATAPROC : (w[21] ? CLS_PSR : CLS_UNDEF);
        GRP_LDST_IM: c = CLS_LDST;
        GRP_LDST_RG: c = w[4] ? CLS_UNDEF : CLS_LDST;
        GRP_LDM:     c = CLS_LDM_STM;
        GRP_BRANCH:  c = CLS_BRANCH;
        GRP_CP_LDST: c = CLS_LDC_STC;
        default:     c = w[24] ? CLS_SWI : (w[4] ? CLS_MRC_MCR : CLS_CDP);
      endcase
      return c;
    endfunction

    function void note_word(input instr_t w);
      pending_class_t p;
      p.word = w;
      p.cls  = predicted_class(w);
      expected_classes.push_back(p);
    endfunction

    function int unsigned pending();
      return expected_classes.size();
    endfunction

    task report(input string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      errors++;
    endtask

    task check_class(input class_t got);
      pending_class_t p;
      if (expected_classes.size() == 0) begin
        report($sformatf("class %0d arrived with nothing expected", got));
      end else begin
        p = expected_classes.pop_front();
        if (got !== p.cls) begin
          report($sformatf("word %08h: class %0d, expected %0d", p.word, got, p.cls));
        end
      end
    endtask
  endclass

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  instr_t in_instruction_word;
  logic   out_valid;
  logic   out_ready;
  class_t out_instruction_class;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;
  class_ledger ledger;

  armv4_instruction_class_decoder_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_instruction_word   (in_instruction_word),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_instruction_class (out_instruction_class)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      out_ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Note the input before checking, so a same-edge result still finds its entry
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        ledger.note_word(in_instruction_word);
      end
      if (out_valid && out_ready) begin
        ledger.check_class(out_instruction_class);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_word(input instr_t w);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid            = 1'b1;
    in_instruction_word = w;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // Hold the sender off until every expected item has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (ledger.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic instr_t random_word();
    instr_t w;
    w = $urandom;
    case ($urandom_range(0, 9))
      2: begin
        // multiply / swap and extra load-store space
        w[27:25] = GRP_DP_REG;
        w[7]     = 1'b1;
        w[4]     = 1'b1;
        if ($urandom_range(0, 1)) begin
          w[6:5] = SH_MUL_SWP;
        end
        if ($urandom_range(0, 1)) begin
          w[24] = 1'b1;
          w[23] = 1'b0;
          w[21] = 1'b0;
        end
      end
      3: begin
        w[27:25] = GRP_DP_REG;
        w[24]    = 1'b1;
        w[23]    = 1'b0;
        w[20]    = 1'b0;
        if ($urandom_range(0, 3) != 0) begin
          w[7:4] = 4'($urandom_range(0, 1));
        end
        if ($urandom_range(0, 1)) begin
          w[22:21] = 2'b01;
        end
      end
      4: begin
        w[27:25] = GRP_DP_IMM;
        w[24]    = 1'b1;
        w[23]    = 1'b0;
        w[20]    = 1'b0;
      end
      5: w[27:25] = GRP_LDST_RG;
      6: w[27:25] = GRP_CP_SWI;
      7: w[27:25] = GRP_DP_REG;
      8: begin
        w[27:25] = GRP_DP_REG;
        w[7]     = 1'b1;
        w[4]     = 1'b1;
      end
      9: w[27:25] = GRP_DP_IMM;
      default: ;
    endcase
    return w;
  endfunction

  instr_t directed_words[$] = '{
    32'h0000_0000, 32'hFFFF_FFFF,
    32'hE10F_0000, 32'hE100_0080, 32'h012F_FF11, 32'hE12F_FF31, 32'hE14F_FF11,
    32'hE000_0091, 32'hE080_0091, 32'hE100_0091, 32'hE120_0091,
    32'hE1D0_00B0, 32'hE1D0_00D0, 32'hE1C0_00D0,
    32'hE328_F001, 32'hE300_0001,
    32'hE590_0000, 32'h7790_0000, 32'hE790_0010,
    32'hE8BD_0000, 32'hEB00_0000, 32'hED90_0000,
    32'hEF00_0000, 32'hEE10_0010, 32'hEE00_0000
  };

  initial begin
    int unsigned idle_by_phase[4];
    int unsigned stall_by_phase[4];
    idle_by_phase       = '{0, 83, 0, 35};
    stall_by_phase      = '{0, 0, 83, 35};
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_instruction_word = '0;
    out_ready           = 1'b0;
    idle_pct            = 0;
    stall_pct           = 0;
    quiet_cycles        = 0;
    ledger              = new();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_words[i]) begin
      send_word(directed_words[i]);
    end
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      for (int n = 0; n < 150; n++) begin
        send_word(random_word());
      end
      drain_results();
    end

    stall_pct = 0;
    repeat (4) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
